FILE: rtl/core/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg: shared types and constants of the damped sinusoid generator
// Fixed-point constants, CORDIC and exponential step tables, register codes
// and the record that travels down the row of cells.
// ----------------------------------------------------------------------------
package dsv_pkg;

    // Row sizes
    localparam int CORDIC_STAGES = 16;
    localparam int EXP_BITS      = 20;
    localparam int NUM_CELLS     = (EXP_BITS > CORDIC_STAGES) ? EXP_BITS : CORDIC_STAGES;

    // Datapath widths
    localparam int W_COR  = 34;
    localparam int W_EXP  = 31;

    // Fixed-point constants
    localparam logic [30:0] ONE_Q30        = 31'd1073741824;
    localparam logic [29:0] HALF_Q30       = 30'd536870912;
    localparam logic [30:0] CORDIC_GAIN    = 31'd652032874;
    localparam logic [30:0] PI_HALF_Q30    = 31'd1686629713;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [15:0] DAMP_MAX       = 16'd32768;

    // Register indexes
    localparam logic [1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [1:0] REG_DAMPING   = 2'd1;
    localparam logic [1:0] REG_NAT_FREQ  = 2'd2;
    localparam logic [1:0] REG_PHASE     = 2'd3;

    // Register reset values
    localparam logic [15:0] AMPLITUDE_RST = 16'hF000;
    localparam logic [15:0] DAMPING_RST   = 16'd6554;
    localparam logic [15:0] NAT_FREQ_RST  = 16'd256;
    localparam logic [15:0] PHASE_RST     = 16'd12868;

    // Root remainder for the reset damping ratio
    localparam logic [30:0] ROOT_RST_REM =
        31'(32'd1073741824 - 32'(DAMPING_RST) * 32'(DAMPING_RST));

    // Record handed from cell to cell
    typedef struct packed {
        logic [W_EXP-1:0]        e;
        logic [EXP_BITS-1:0]     xbits;
        logic signed [W_COR-1:0] x;
        logic signed [W_COR-1:0] y;
        logic signed [W_COR-1:0] z;
        logic [1:0]              quad;
    } chain_t;

    // Limit the damping ratio to one
    function automatic logic [15:0] clamp_damp(input logic [15:0] h);
        return (h > DAMP_MAX) ? DAMP_MAX : h;
    endfunction

    // CORDIC rotation angle of step i, Q30 radians
    function automatic logic [W_COR-1:0] atan_at(input int i);
        logic [W_COR-1:0] a;
        case (i)
            0:       a = 34'd843314857;
            1:       a = 34'd497837829;
            2:       a = 34'd263043837;
            3:       a = 34'd133525159;
            4:       a = 34'd67021687;
            5:       a = 34'd33543516;
            6:       a = 34'd16775851;
            7:       a = 34'd8388437;
            8:       a = 34'd4194283;
            9:       a = 34'd2097149;
            default: a = (i <= 30) ? (34'd1 << (30 - i)) : 34'd0;
        endcase
        return a;
    endfunction

    // exp(-2^(b-16)) in Q30
    function automatic logic [29:0] exp_factor(input int b);
        logic [29:0] f;
        case (b)
            0:       f = 30'd1073725440;
            1:       f = 30'd1073709056;
            2:       f = 30'd1073676290;
            3:       f = 30'd1073610760;
            4:       f = 30'd1073479712;
            5:       f = 30'd1073217664;
            6:       f = 30'd1072693760;
            7:       f = 30'd1071646719;
            8:       f = 30'd1069555701;
            9:       f = 30'd1065385899;
            10:      f = 30'd1057095000;
            11:      f = 30'd1040706261;
            12:      f = 30'd1008687096;
            13:      f = 30'd947573834;
            14:      f = 30'd836230973;
            15:      f = 30'd651257337;
            16:      f = 30'd395007542;
            17:      f = 30'd145315154;
            18:      f = 30'd19666268;
            19:      f = 30'd360200;
            default: f = 30'd0;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/core/damped_sinusoid_value.sv
// ----------------------------------------------------------------------------
// damped_sinusoid_value: amp * exp(-h*n*t) * sin(sqrt(1-h*h)*n*t + phase)
// 7 front stages, 20 cells and 2 output stages; one item per cycle unless
// stalled. Reset and each damping write hold in_stall high while the root runs.
// ----------------------------------------------------------------------------
module damped_sinusoid_value (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [15:0]        wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [23:0]        time_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] wave_value
);

    localparam int NC = dsv_pkg::NUM_CELLS;

    logic [15:0] amp_reg, damp_reg, freq_reg, phase_reg;
    logic        root_busy;
    logic [15:0] root;
    logic        front_ready;

    dsv_pkg::chain_t cd [NC+1];
    logic            cv [NC+1];
    logic            cr [NC+1];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg   <= dsv_pkg::AMPLITUDE_RST;
            damp_reg  <= dsv_pkg::DAMPING_RST;
            freq_reg  <= dsv_pkg::NAT_FREQ_RST;
            phase_reg <= dsv_pkg::PHASE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                dsv_pkg::REG_AMPLITUDE: amp_reg   <= wr_data;
                dsv_pkg::REG_DAMPING:   damp_reg  <= wr_data;
                dsv_pkg::REG_NAT_FREQ:  freq_reg  <= wr_data;
                dsv_pkg::REG_PHASE:     phase_reg <= wr_data;
                default:                amp_reg   <= amp_reg;
            endcase
        end
    end

    dsv_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (wr_en && (wr_index == dsv_pkg::REG_DAMPING)),
        .damp_new (wr_data),
        .busy     (root_busy),
        .root     (root)
    );

    assign in_stall = root_busy || !front_ready;

    dsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid && !root_busy),
        .in_ready   (front_ready),
        .time_value (time_value),
        .nat_freq   (freq_reg),
        .damp       (dsv_pkg::clamp_damp(damp_reg)),
        .root       (root),
        .phase      (phase_reg),
        .out_valid  (cv[0]),
        .out_ready  (cr[0]),
        .out_data   (cd[0])
    );

    // Row of cells: exponent factors and CORDIC rotations
    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        dsv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .exp_en    (g < dsv_pkg::EXP_BITS),
            .cor_en    (g < dsv_pkg::CORDIC_STAGES),
            .factor    (dsv_pkg::exp_factor(g)),
            .atan_step (dsv_pkg::atan_at(g)),
            .shift_amt (5'(g)),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .in_data   (cd[g]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1]),
            .out_data  (cd[g+1])
        );
    end

    dsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cv[NC]),
        .in_ready   (cr[NC]),
        .in_data    (cd[NC]),
        .amp        ($signed(amp_reg)),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .wave_value (wave_value)
    );

endmodule

FILE: rtl/core/dsv_root.sv
// ----------------------------------------------------------------------------
// dsv_root: damped frequency factor unit
// Computes floor(sqrt(2^30 - h*h)) one root digit at a time, from the top bit down,
// after reset and after each write of the damping ratio.
// ----------------------------------------------------------------------------
module dsv_root (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] damp_new,
    output logic        busy,
    output logic [15:0] root
);

    logic [30:0] rem_reg;
    logic [30:0] root_reg;
    logic [3:0]  k_reg;
    logic        busy_reg;

    logic [15:0] hc;
    logic [30:0] bit_val;
    logic [31:0] trial;

    always_comb
    begin
        hc      = dsv_pkg::clamp_damp(damp_new);
        bit_val = 31'd1 << {k_reg, 1'b0};
        trial   = 32'(root_reg) + 32'(bit_val);
    end

    // Restart on a damping write, else advance one root digit while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= dsv_pkg::ROOT_RST_REM;
            root_reg <= '0;
            k_reg    <= 4'd15;
            busy_reg <= 1'b1;
        end
        else if (start)
        begin
            rem_reg  <= 31'(32'd1073741824 - 32'(hc) * 32'(hc));
            root_reg <= '0;
            k_reg    <= 4'd15;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (32'(rem_reg) >= trial)
            begin
                rem_reg  <= rem_reg - trial[30:0];
                root_reg <= (root_reg >> 1) + bit_val;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            if (k_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                k_reg <= k_reg - 4'd1;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg[15:0];

endmodule

FILE: rtl/core/dsv_front.sv
// ----------------------------------------------------------------------------
// dsv_front: argument pipeline
// Seven stages from time to decay exponent, CORDIC angle and quadrant.
// ----------------------------------------------------------------------------
module dsv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [23:0]         time_value,
    input  logic [15:0]         nat_freq,
    input  logic [15:0]         damp,
    input  logic [15:0]         root,
    input  logic [15:0]         phase,
    output logic                out_valid,
    input  logic                out_ready,
    output dsv_pkg::chain_t     out_data
);

    logic [7:1] vld_reg;
    logic [8:1] rdy;

    logic [23:0] t1_reg;
    logic [39:0] w2_reg;
    logic [35:0] ph_lo3_reg, ph_hi3_reg, pt_lo3_reg, pt_hi3_reg;
    logic [19:0] x4_reg, x5_reg, x6_reg, x7_reg;
    logic        xz4_reg, xz5_reg, xz6_reg, xz7_reg;
    logic [51:0] th4_reg;
    logic [55:0] p_lo5_reg, p_hi5_reg;
    logic [31:0] turn6_reg;
    logic [30:0] z7_reg;
    logic [1:0]  quad7_reg;

    logic [55:0] ph_sum, pt_sum;
    logic [32:0] x_full;
    logic [51:0] th_next;
    logic [51:0] turn_sum;
    logic [60:0] z_prod;

    // Stage ready chain: a stage moves when empty or when its successor moves
    always_comb
    begin
        rdy[8] = out_ready;
        for (int k = 7; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 7; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Combine partial products, form the phase angle and scale the turn to the CORDIC angle
    always_comb
    begin
        ph_sum   = {ph_hi3_reg, 20'd0} + 56'(ph_lo3_reg);
        pt_sum   = {pt_hi3_reg, 20'd0} + 56'(pt_lo3_reg);
        x_full   = ph_sum[55:23];
        th_next  = 52'(pt_sum[55:19]) + {{29{phase[15]}}, phase, 7'd0};
        turn_sum = p_lo5_reg[51:0] + {p_hi5_reg[25:0], 26'd0};
        z_prod   = 61'(turn6_reg[29:0]) * 61'(dsv_pkg::PI_HALF_Q30);
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            t1_reg <= time_value;
        end
        if (rdy[2])
        begin
            w2_reg <= 40'(nat_freq) * 40'(t1_reg);
        end
        if (rdy[3])
        begin
            ph_lo3_reg <= 36'(damp) * 36'(w2_reg[19:0]);
            ph_hi3_reg <= 36'(damp) * 36'(w2_reg[39:20]);
            pt_lo3_reg <= 36'(root) * 36'(w2_reg[19:0]);
            pt_hi3_reg <= 36'(root) * 36'(w2_reg[39:20]);
        end
        if (rdy[4])
        begin
            x4_reg  <= x_full[19:0];
            xz4_reg <= |x_full[32:20];
            th4_reg <= th_next;
        end
        if (rdy[5])
        begin
            p_lo5_reg <= 56'(th4_reg[25:0]) * 56'(dsv_pkg::INV_TWO_PI_Q32);
            p_hi5_reg <= 56'(th4_reg[51:26]) * 56'(dsv_pkg::INV_TWO_PI_Q32);
            x5_reg    <= x4_reg;
            xz5_reg   <= xz4_reg;
        end
        if (rdy[6])
        begin
            turn6_reg <= turn_sum[51:20];
            x6_reg    <= x5_reg;
            xz6_reg   <= xz5_reg;
        end
        if (rdy[7])
        begin
            z7_reg    <= z_prod[60:30];
            quad7_reg <= turn6_reg[31:30];
            x7_reg    <= x6_reg;
            xz7_reg   <= xz6_reg;
        end
    end

    // Seed the record for the cell row
    always_comb
    begin
        out_data.e     = xz7_reg ? '0 : dsv_pkg::ONE_Q30;
        out_data.xbits = x7_reg;
        out_data.x     = 34'(dsv_pkg::CORDIC_GAIN);
        out_data.y     = '0;
        out_data.z     = {3'd0, z7_reg};
        out_data.quad  = quad7_reg;
    end

    assign in_ready  = rdy[1];
    assign out_valid = vld_reg[7];

endmodule

FILE: rtl/core/dsv_cell.sv
// ----------------------------------------------------------------------------
// dsv_cell: one cell of the row
// Applies its exponential factor when enabled and its bit is set, and its
// CORDIC rotation when enabled, then hands the record to the next cell.
// ----------------------------------------------------------------------------
module dsv_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      exp_en,
    input  logic                      cor_en,
    input  logic [29:0]               factor,
    input  logic [dsv_pkg::W_COR-1:0] atan_step,
    input  logic [4:0]                shift_amt,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dsv_pkg::chain_t           in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dsv_pkg::chain_t           out_data
);

    logic            vld_reg;
    dsv_pkg::chain_t data_reg;
    dsv_pkg::chain_t data_next;

    logic [60:0]                    e_prod;
    logic signed [dsv_pkg::W_COR-1:0] dx, dy, ang;

    always_comb
    begin
        e_prod = 61'(in_data.e) * 61'(factor) + 61'(dsv_pkg::HALF_Q30);
        dx     = in_data.y >>> shift_amt;
        dy     = in_data.x >>> shift_amt;
        ang    = $signed(atan_step);

        data_next       = in_data;
        data_next.xbits = in_data.xbits >> 1;
        // Multiply in the factor when this exponent bit is set
        if (exp_en && in_data.xbits[0])
        begin
            data_next.e = e_prod[60:30];
        end
        // Rotate toward zero residual angle
        if (cor_en)
        begin
            if (!in_data.z[dsv_pkg::W_COR-1])
            begin
                data_next.x = in_data.x - dx;
                data_next.y = in_data.y + dy;
                data_next.z = in_data.z - ang;
            end
            else
            begin
                data_next.x = in_data.x + dx;
                data_next.y = in_data.y - dy;
                data_next.z = in_data.z + ang;
            end
        end
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/dsv_back.sv
// ----------------------------------------------------------------------------
// dsv_back: output scaling
// Picks the sine by quadrant, scales by decay and amplitude, saturates and
// holds the item in the output register.
// ----------------------------------------------------------------------------
module dsv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dsv_pkg::chain_t    in_data,
    input  logic signed [15:0] amp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] wave_value
);

    logic                      v1_reg;
    logic signed [33:0]        m1_reg;
    logic                      ov_reg;
    logic signed [15:0]        wave_reg;

    logic                      rdy1, rdy2;
    logic signed [33:0]        sn;
    logic signed [65:0]        m_prod;
    logic signed [49:0]        r_prod;
    logic signed [19:0]        r;
    logic signed [15:0]        wave_next;

    assign rdy2 = !ov_reg || !out_stall;
    assign rdy1 = !v1_reg || rdy2;

    // Sine by quadrant, then decay product
    always_comb
    begin
        case (in_data.quad)
            2'd0:    sn = in_data.y;
            2'd1:    sn = in_data.x;
            2'd2:    sn = -in_data.y;
            default: sn = -in_data.x;
        endcase
        m_prod = 66'($signed({1'b0, in_data.e})) * 66'(sn) + 66'(dsv_pkg::HALF_Q30);
    end

    // Amplitude product and saturation
    always_comb
    begin
        r_prod = 50'(amp) * 50'(m1_reg) + 50'(dsv_pkg::HALF_Q30);
        r      = r_prod[49:30];
        if (r > 20'sd32767)
        begin
            wave_next = 16'sh7FFF;
        end
        else if (r < -20'sd32768)
        begin
            wave_next = -16'sh8000;
        end
        else
        begin
            wave_next = r[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                ov_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            m1_reg <= m_prod[63:30];
        end
        if (rdy2)
        begin
            wave_reg <= wave_next;
        end
    end

    assign in_ready   = rdy1;
    assign out_valid  = ov_reg;
    assign wave_value = wave_reg;

endmodule
